// ===== src/atet_pkg.sv =====
// ----------------------------------------------------------------------------
// atet_pkg
// shared types, constants and the arctangent table for the tilt tracker
// ----------------------------------------------------------------------------
package atet_pkg;

    // handshake status of an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // square root unit widths
    localparam int SQ_IN_W   = 48;
    localparam int SQ_ROOT_W = 24;
    localparam int SQ_REM_W  = 26;

    // cordic widths
    localparam int CD_XY_W   = 28;
    localparam int CD_Z_W    = 26;
    localparam int ATAN_W    = 22;
    localparam int ATAN_IDX_W = 5;

    localparam logic signed [CD_Z_W-1:0] DEG90 = 26'sd5898240;

    // angle limits in 1/64 degree
    localparam logic signed [15:0] HEAD_LIM  = 16'sd11520;
    localparam logic signed [15:0] TILT_LIM  = 16'sd5760;
    localparam logic signed [18:0] FULL_TURN = 19'sd23040;

    // 6681/65536 approximates 1/9.81
    localparam logic signed [15:0] MPS2_TO_G = 16'sd6681;

    // floor(n/10) as (n * EMA_RECIP) >> EMA_SHIFT, exact for n below 2^19
    localparam logic [19:0] EMA_RECIP = 20'd419431;
    localparam int          EMA_SHIFT = 22;

    // arctangent of 2^-i in degrees * 65536
    function automatic logic [ATAN_W-1:0] atan_val(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        begin
            unique case (idx)
                5'd0:    v = 22'd2949120;
                5'd1:    v = 22'd1740967;
                5'd2:    v = 22'd919879;
                5'd3:    v = 22'd466945;
                5'd4:    v = 22'd234379;
                5'd5:    v = 22'd117304;
                5'd6:    v = 22'd58666;
                5'd7:    v = 22'd29335;
                5'd8:    v = 22'd14668;
                5'd9:    v = 22'd7334;
                5'd10:   v = 22'd3667;
                5'd11:   v = 22'd1833;
                5'd12:   v = 22'd917;
                5'd13:   v = 22'd458;
                5'd14:   v = 22'd229;
                5'd15:   v = 22'd115;
                5'd16:   v = 22'd57;
                5'd17:   v = 22'd29;
                5'd18:   v = 22'd14;
                5'd19:   v = 22'd7;
                5'd20:   v = 22'd4;
                5'd21:   v = 22'd2;
                5'd22:   v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== src/atet_sqrt.sv =====
// ----------------------------------------------------------------------------
// atet_sqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module atet_sqrt
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [atet_pkg::SQ_IN_W-1:0]      radicand,
    output logic [atet_pkg::SQ_ROOT_W-1:0]    root,
    output logic [atet_pkg::SQ_REM_W-1:0]     remainder,
    output atet_pkg::unit_stat_t              stat
);

    localparam int CAND_W = atet_pkg::SQ_REM_W + 2;
    localparam int CNT_W  = $clog2(atet_pkg::SQ_ROOT_W + 1);

    logic [atet_pkg::SQ_IN_W-1:0]   n_reg,    n_next;
    logic [atet_pkg::SQ_ROOT_W-1:0] root_reg, root_next;
    logic [atet_pkg::SQ_REM_W-1:0]  rem_reg,  rem_next;
    logic [CNT_W-1:0]               cnt_reg,  cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [CAND_W-1:0]              cand;
    logic [CAND_W-1:0]              trial;

    always_comb
    begin
        cand  = {rem_reg, n_reg[atet_pkg::SQ_IN_W-1 -: 2]};
        trial = {2'b00, root_reg, 2'b01};
        n_next    = n_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next    = radicand;
            root_next = '0;
            rem_next  = '0;
            cnt_next  = CNT_W'(atet_pkg::SQ_ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[atet_pkg::SQ_IN_W-3:0], 2'b00};
            if (cand >= trial)
            begin
                rem_next  = atet_pkg::SQ_REM_W'(cand - trial);
                root_next = {root_reg[atet_pkg::SQ_ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = atet_pkg::SQ_REM_W'(cand);
                root_next = {root_reg[atet_pkg::SQ_ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign root      = root_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== src/atet_cordic.sv =====
// ----------------------------------------------------------------------------
// atet_cordic
// vectoring cordic arctangent, one micro-rotation per cycle
// ----------------------------------------------------------------------------
module atet_cordic
#(
    parameter int CORDIC_ITERS = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [atet_pkg::CD_XY_W-1:0]    y_in,
    input  logic signed [atet_pkg::CD_XY_W-1:0]    x_in,
    output logic signed [atet_pkg::CD_Z_W-1:0]     angle,
    output atet_pkg::unit_stat_t                   stat
);

    localparam int IW = $clog2(CORDIC_ITERS);

    logic signed [atet_pkg::CD_XY_W-1:0] x_reg, x_next;
    logic signed [atet_pkg::CD_XY_W-1:0] y_reg, y_next;
    logic signed [atet_pkg::CD_Z_W-1:0]  z_reg, z_next;
    logic [IW-1:0]                       i_reg, i_next;
    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic signed [atet_pkg::CD_XY_W-1:0] xs, ys;
    logic signed [atet_pkg::CD_Z_W-1:0]  at;

    always_comb
    begin
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        at = $signed({4'b0000, atet_pkg::atan_val(atet_pkg::ATAN_IDX_W'(i_reg))});
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            i_next = '0;
            priority if (x_in == '0 && y_in == '0)
            begin
                // zero vector reads as angle zero
                z_next    = '0;
                done_next = 1'b1;
            end
            else if (x_in < 0)
            begin
                busy_next = 1'b1;
                if (y_in >= 0)
                begin
                    x_next = y_in;
                    y_next = -x_in;
                    z_next = atet_pkg::DEG90;
                end
                else
                begin
                    x_next = -y_in;
                    y_next = x_in;
                    z_next = -atet_pkg::DEG90;
                end
            end
            else
            begin
                busy_next = 1'b1;
                x_next    = x_in;
                y_next    = y_in;
                z_next    = '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            i_next = i_reg + 1'b1;
            if (i_reg == IW'(CORDIC_ITERS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign angle     = z_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== src/accel_tilt_ema_tracker_top.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_ema_tracker_top
// accelerometer tilt and magnitude tracker with exponential smoothing
// ----------------------------------------------------------------------------
// One request carries a three-axis Q8.8 sample (or a peak clear). The block
// scales the sample to g when the input_in_g register is 0, forms the planar
// and total magnitudes, heading, pitch and roll, smooths all eight values with
// an alpha 0.4 filter and returns one result per request. A sample request
// uses one shared 16x16 multiplier for unit scaling and squares, four passes
// of a bit-serial square root and three passes of a one-rotation-per-cycle
// cordic, then states EMA_A and EMA_B for each filtered value; a peak clear
// goes straight to the done state. in_stall is high while a request is being
// worked on; a finished result may wait on out_stall while the next request
// is accepted. The first sample after reset or after a unit change loads the
// filters directly. Register input_in_g lives at byte address 0; the user must
// write it only while the block is idle, as the block does not enforce this.
// ----------------------------------------------------------------------------
module accel_tilt_ema_tracker_top
#(
    parameter int CORDIC_ITERS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic signed [15:0] sample_x,
    input  logic signed [15:0] sample_y,
    input  logic signed [15:0] sample_z,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] filt_x,
    output logic signed [15:0] filt_y,
    output logic signed [15:0] filt_z,
    output logic [15:0]        filt_total,
    output logic [15:0]        filt_planar,
    output logic signed [14:0] filt_heading,
    output logic signed [13:0] filt_pitch,
    output logic signed [13:0] filt_roll,
    output logic [15:0]        peak_total,
    output logic               changed
);

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CONV   = 4'd1;
    localparam logic [3:0] ST_SQ     = 4'd2;
    localparam logic [3:0] ST_SQRT   = 4'd3;
    localparam logic [3:0] ST_SQWAIT = 4'd4;
    localparam logic [3:0] ST_CORD   = 4'd5;
    localparam logic [3:0] ST_CWAIT  = 4'd6;
    localparam logic [3:0] ST_EMA_A  = 4'd7;
    localparam logic [3:0] ST_EMA_B  = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;

    // request codes and register index
    localparam logic OP_SAMPLE      = 1'b0;
    localparam logic OP_CLEAR       = 1'b1;
    localparam logic REG_INPUT_IN_G = 1'b0;

    // filter channel numbers
    localparam logic [2:0] CH_TOTAL   = 3'd3;
    localparam logic [2:0] CH_PLANAR  = 3'd4;
    localparam logic [2:0] CH_HEADING = 3'd5;
    localparam logic [2:0] CH_LAST    = 3'd7;

    localparam int AW = 18;  // filter arithmetic width

    // control state
    logic [3:0]  state_reg, state_next;
    logic [2:0]  cnt_reg,   cnt_next;
    logic        in_g_reg,  in_g_next;
    logic        primed_reg, primed_next;
    logic [15:0] peak_reg,  peak_next;
    logic        chg_reg,   chg_next;
    logic        ovld_reg,  ovld_next;
    logic signed [AW-1:0] avg_reg [8];
    logic signed [AW-1:0] avg_wr;
    logic                 avg_we;

    // payload registers
    logic                op_reg;
    logic signed [15:0]  raw_reg [3];
    logic signed [15:0]  g_reg [3];
    logic [31:0]         sq_reg [3];
    logic [15:0]         planar_reg, total_reg;
    logic [23:0]         den_p_reg, den_r_reg;
    logic signed [15:0]  ang_reg [3];
    logic [18:0]         n_reg;
    logic                neg_reg;
    logic signed [AW-1:0] val_reg;

    // output registers
    logic signed [15:0] o_x_reg, o_y_reg, o_z_reg;
    logic [15:0]        o_total_reg, o_planar_reg, o_peak_reg;
    logic signed [14:0] o_head_reg;
    logic signed [13:0] o_pitch_reg, o_roll_reg;
    logic               o_chg_reg;

    logic accept;
    logic cfg_wr;
    logic load_out;

    // shared multiplier
    logic signed [15:0] mul_a, mul_b;
    logic signed [31:0] mul_p;
    logic signed [31:0] conv_sum;
    logic signed [15:0] g_conv;

    // square root unit
    logic [atet_pkg::SQ_IN_W-1:0]   sq_in;
    logic [atet_pkg::SQ_ROOT_W-1:0] sq_root;
    logic [atet_pkg::SQ_REM_W-1:0]  sq_rem;
    atet_pkg::unit_stat_t           sq_stat;
    logic [31:0]                    sum_xy, sum_xyz, sum_yz, sum_xz;
    logic [15:0]                    root_rnd;

    // cordic unit
    logic signed [atet_pkg::CD_XY_W-1:0] cd_y, cd_x;
    logic signed [atet_pkg::CD_Z_W-1:0]  cd_z;
    atet_pkg::unit_stat_t                cd_stat;
    logic signed [atet_pkg::CD_Z_W-1:0]  z_rnd;
    logic signed [15:0]                  ang64, ang_lim, ang_sat;

    // filter step
    logic signed [AW-1:0] ch_val, ch_avg;
    logic signed [AW:0]   diff;
    logic [AW-1:0]        mag;
    logic [38:0]          q_prod;
    logic signed [AW-1:0] q_step;
    logic signed [AW-1:0] sum_avg;
    logic [15:0]          peak_upd;

    assign pready   = 1'b1;
    assign prdata   = {31'd0, in_g_reg};
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_INPUT_IN_G);
    assign load_out = (state_reg == ST_DONE) && (!ovld_reg || !out_stall);

    // unit scaling and squaring share one multiplier
    always_comb
    begin
        if (state_reg == ST_CONV)
        begin
            mul_a = raw_reg[cnt_reg[1:0]];
            mul_b = atet_pkg::MPS2_TO_G;
        end
        else
        begin
            mul_a = g_reg[cnt_reg[1:0]];
            mul_b = g_reg[cnt_reg[1:0]];
        end
        mul_p    = mul_a * mul_b;
        conv_sum = mul_p + 32'sd32768;
        g_conv   = in_g_reg ? raw_reg[cnt_reg[1:0]] : conv_sum[31:16];
    end

    // square root operands: planar, total, pitch and roll denominators
    always_comb
    begin
        sum_xy  = sq_reg[0] + sq_reg[1];
        sum_xyz = sum_xy + sq_reg[2];
        sum_yz  = sq_reg[1] + sq_reg[2];
        sum_xz  = sq_reg[0] + sq_reg[2];
        unique case (cnt_reg[1:0])
            2'd0:    sq_in = {16'd0, sum_xy};
            2'd1:    sq_in = {16'd0, sum_xyz};
            2'd2:    sq_in = {sum_yz, 16'd0};
            default: sq_in = {sum_xz, 16'd0};
        endcase
        // round to nearest when the remainder exceeds the root
        root_rnd = sq_root[15:0] + 16'((sq_rem > {2'b00, sq_root}) ? 1 : 0);
    end

    atet_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == ST_SQRT),
        .radicand  (sq_in),
        .root      (sq_root),
        .remainder (sq_rem),
        .stat      (sq_stat)
    );

    // cordic operands: heading, pitch, roll
    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:
            begin
                cd_y = {{4{g_reg[1][15]}}, g_reg[1], 8'd0};
                cd_x = {{4{g_reg[0][15]}}, g_reg[0], 8'd0};
            end
            2'd1:
            begin
                cd_y = {{4{g_reg[0][15]}}, g_reg[0], 8'd0};
                cd_x = {4'd0, den_p_reg};
            end
            default:
            begin
                cd_y = {{4{g_reg[1][15]}}, g_reg[1], 8'd0};
                cd_x = {4'd0, den_r_reg};
            end
        endcase
        z_rnd   = cd_z + 26'sd512;
        ang64   = z_rnd[atet_pkg::CD_Z_W-1:10];
        ang_lim = (cnt_reg[1:0] == 2'd0) ? atet_pkg::HEAD_LIM : atet_pkg::TILT_LIM;
        priority if (ang64 > ang_lim)
            ang_sat = ang_lim;
        else if (ang64 < -ang_lim)
            ang_sat = -ang_lim;
        else
            ang_sat = ang64;
    end

    atet_cordic #(.CORDIC_ITERS(CORDIC_ITERS)) u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_CORD),
        .y_in  (cd_y),
        .x_in  (cd_x),
        .angle (cd_z),
        .stat  (cd_stat)
    );

    // filter step, states EMA_A and EMA_B per channel
    always_comb
    begin
        unique case (cnt_reg)
            3'd0:    ch_val = AW'(g_reg[0]);
            3'd1:    ch_val = AW'(g_reg[1]);
            3'd2:    ch_val = AW'(g_reg[2]);
            3'd3:    ch_val = $signed({2'b00, total_reg});
            3'd4:    ch_val = $signed({2'b00, planar_reg});
            3'd5:    ch_val = AW'(ang_reg[0]);
            3'd6:    ch_val = AW'(ang_reg[1]);
            default: ch_val = AW'(ang_reg[2]);
        endcase
        ch_avg = avg_reg[cnt_reg];
        diff   = (AW+1)'(ch_val) - (AW+1)'(ch_avg);
        // heading difference goes the short way round
        if (cnt_reg == CH_HEADING)
        begin
            if (diff > (AW+1)'(atet_pkg::HEAD_LIM))
                diff = diff - atet_pkg::FULL_TURN;
            else if (diff < -(AW+1)'(atet_pkg::HEAD_LIM))
                diff = diff + atet_pkg::FULL_TURN;
        end
        mag     = diff[AW] ? AW'(-diff) : AW'(diff);
        q_prod  = n_reg * atet_pkg::EMA_RECIP;
        q_step  = neg_reg ? -AW'(q_prod >> atet_pkg::EMA_SHIFT)
                          :  AW'(q_prod >> atet_pkg::EMA_SHIFT);
        sum_avg = primed_reg ? ch_avg + q_step : val_reg;
        if (cnt_reg == CH_HEADING)
        begin
            if (sum_avg > AW'(atet_pkg::HEAD_LIM))
                sum_avg = sum_avg - AW'(atet_pkg::FULL_TURN);
            else if (sum_avg < -AW'(atet_pkg::HEAD_LIM))
                sum_avg = sum_avg + AW'(atet_pkg::FULL_TURN);
        end
        avg_wr = sum_avg;
        avg_we = (state_reg == ST_EMA_B);
        // peak follows the raw total on sample requests only
        if (op_reg == OP_CLEAR)
            peak_upd = '0;
        else if (total_reg > peak_reg)
            peak_upd = total_reg;
        else
            peak_upd = peak_reg;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        in_g_next   = in_g_reg;
        primed_next = primed_reg;
        peak_next   = peak_reg;
        chg_next    = chg_reg;
        ovld_next   = ovld_reg && out_stall;
        if (cfg_wr && (pwdata[0] != in_g_reg))
        begin
            // unit change restarts the filters and the peak
            in_g_next   = pwdata[0];
            primed_next = 1'b0;
            peak_next   = '0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = '0;
                    chg_next   = 1'b0;
                    state_next = (op == OP_CLEAR) ? ST_DONE : ST_CONV;
                end
            end
            ST_CONV, ST_SQ:
            begin
                if (cnt_reg == 3'd2)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == ST_CONV) ? ST_SQ : ST_SQRT;
                end
                else
                    cnt_next = cnt_reg + 3'd1;
            end
            ST_SQRT:
                state_next = ST_SQWAIT;
            ST_SQWAIT:
            begin
                if (sq_stat.done)
                begin
                    if (cnt_reg == 3'd3)
                    begin
                        cnt_next   = '0;
                        state_next = ST_CORD;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 3'd1;
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_CORD:
                state_next = ST_CWAIT;
            ST_CWAIT:
            begin
                if (cd_stat.done)
                begin
                    if (cnt_reg == 3'd2)
                    begin
                        cnt_next   = '0;
                        state_next = ST_EMA_A;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 3'd1;
                        state_next = ST_CORD;
                    end
                end
            end
            ST_EMA_A:
                state_next = ST_EMA_B;
            ST_EMA_B:
            begin
                chg_next = chg_reg || (avg_wr != ch_avg);
                if (cnt_reg == CH_LAST)
                    state_next = ST_DONE;
                else
                begin
                    cnt_next   = cnt_reg + 3'd1;
                    state_next = ST_EMA_A;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    peak_next  = peak_upd;
                    ovld_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (op_reg == OP_SAMPLE)
                        primed_next = 1'b1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            in_g_reg   <= 1'b0;
            primed_reg <= 1'b0;
            peak_reg   <= '0;
            chg_reg    <= 1'b0;
            ovld_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
                avg_reg[i] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            in_g_reg   <= in_g_next;
            primed_reg <= primed_next;
            peak_reg   <= peak_next;
            chg_reg    <= chg_next;
            ovld_reg   <= ovld_next;
            if (avg_we)
                avg_reg[cnt_reg] <= avg_wr;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op;
            raw_reg[0] <= sample_x;
            raw_reg[1] <= sample_y;
            raw_reg[2] <= sample_z;
        end
        if (state_reg == ST_CONV)
            g_reg[cnt_reg[1:0]] <= g_conv;
        if (state_reg == ST_SQ)
            sq_reg[cnt_reg[1:0]] <= mul_p;
        if (state_reg == ST_SQWAIT && sq_stat.done)
        begin
            unique case (cnt_reg[1:0])
                2'd0:    planar_reg <= root_rnd;
                2'd1:    total_reg  <= root_rnd;
                2'd2:    den_p_reg  <= sq_root;
                default: den_r_reg  <= sq_root;
            endcase
        end
        if (state_reg == ST_CWAIT && cd_stat.done)
            ang_reg[cnt_reg[1:0]] <= ang_sat;
        if (state_reg == ST_EMA_A)
        begin
            n_reg   <= 19'({mag, 2'b00} + 20'd5);
            neg_reg <= diff[AW];
            val_reg <= ch_val;
        end
        if (load_out)
        begin
            o_x_reg      <= avg_reg[0][15:0];
            o_y_reg      <= avg_reg[1][15:0];
            o_z_reg      <= avg_reg[2][15:0];
            o_total_reg  <= avg_reg[CH_TOTAL][15:0];
            o_planar_reg <= avg_reg[CH_PLANAR][15:0];
            o_head_reg   <= avg_reg[CH_HEADING][14:0];
            o_pitch_reg  <= avg_reg[6][13:0];
            o_roll_reg   <= avg_reg[CH_LAST][13:0];
            o_peak_reg   <= peak_upd;
            o_chg_reg    <= chg_reg || (peak_upd != peak_reg);
        end
    end

    assign out_valid    = ovld_reg;
    assign filt_x       = o_x_reg;
    assign filt_y       = o_y_reg;
    assign filt_z       = o_z_reg;
    assign filt_total   = o_total_reg;
    assign filt_planar  = o_planar_reg;
    assign filt_heading = o_head_reg;
    assign filt_pitch   = o_pitch_reg;
    assign filt_roll    = o_roll_reg;
    assign peak_total   = o_peak_reg;
    assign changed      = o_chg_reg;

    // stored heading always stays on the half turn either side of zero
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        avg_reg[CH_HEADING] <= AW'(atet_pkg::HEAD_LIM) &&
        avg_reg[CH_HEADING] >= -AW'(atet_pkg::HEAD_LIM))
        else $error("stored heading out of range");

    // square root finishes only while the sequencer waits for it
    a_sq_done: assert property (@(posedge clk) disable iff (!rst_n)
        sq_stat.done |-> state_reg == ST_SQWAIT)
        else $error("square root done outside its wait state");

    // cordic finishes only while the sequencer waits for it
    a_cd_done: assert property (@(posedge clk) disable iff (!rst_n)
        cd_stat.done |-> state_reg == ST_CWAIT)
        else $error("cordic done outside its wait state");

    // both units are quiet when no request is in flight
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !sq_stat.busy && !cd_stat.busy)
        else $error("arithmetic unit busy while idle");

endmodule

// ===== test/tb_accel_tilt_ema_tracker_top.sv =====
// ----------------------------------------------------------------------------
// tb_accel_tilt_ema_tracker_top
// self-checking bench for the accelerometer tilt and magnitude tracker
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a clocked driver; a clocked monitor works
// out the expected result of every accepted request with its own model of the
// tracker and checks every result against it. The run covers both units,
// directed extremes and special cases, then random phases of mostly
// realistic samples with some full-range noise and peak clears.
// ----------------------------------------------------------------------------
module tb_accel_tilt_ema_tracker_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int       CORDIC_STEPS = 16;
    localparam longint   QUARTER_TURN = 90 * 65536;
    localparam int       HEADING_MAX  = 11520;
    localparam int       TILT_MAX     = 5760;
    localparam int       TURN_64THS   = 23040;
    localparam longint   MPS2_SCALE   = 6681;
    localparam int       SETTLE_CYC   = 200;
    localparam longint   CYCLE_LIMIT  = 3000000;
    localparam logic [2:0] ADDR_INPUT_IN_G = 3'd0;
    localparam logic [2:0] ADDR_UNUSED     = 3'd4;

    typedef enum logic { OP_SAMPLE = 1'b0, OP_CLEAR = 1'b1 } op_e;

    typedef struct {
        op_e         kind;
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
    } request_t;

    typedef struct {
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] fz;
        logic [15:0] ftotal;
        logic [15:0] fplanar;
        logic [14:0] fheading;
        logic [13:0] fpitch;
        logic [13:0] froll;
        logic [15:0] peak;
        logic        chg;
    } tilt_result_t;

    // arctangent of 2^-i in degrees * 65536
    localparam longint ATAN_Q16 [16] = '{2949120, 1740967, 919879, 466945, 234379,
        117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               op = 1'b0;
    logic signed [15:0] sample_x = '0;
    logic signed [15:0] sample_y = '0;
    logic signed [15:0] sample_z = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] filt_x;
    logic signed [15:0] filt_y;
    logic signed [15:0] filt_z;
    logic [15:0]        filt_total;
    logic [15:0]        filt_planar;
    logic signed [14:0] filt_heading;
    logic signed [13:0] filt_pitch;
    logic signed [13:0] filt_roll;
    logic [15:0]        peak_total;
    logic               changed;

    accel_tilt_ema_tracker_top #(.CORDIC_ITERS(CORDIC_STEPS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .op(op),
        .sample_x(sample_x), .sample_y(sample_y), .sample_z(sample_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .filt_x(filt_x), .filt_y(filt_y), .filt_z(filt_z),
        .filt_total(filt_total), .filt_planar(filt_planar),
        .filt_heading(filt_heading), .filt_pitch(filt_pitch),
        .filt_roll(filt_roll), .peak_total(peak_total), .changed(changed)
    );

    always #4 clk = ~clk;

    // tracker model state, mirrors the block's registers
    bit unit_is_g;
    int avg_x, avg_y, avg_z, avg_total, avg_planar;
    int avg_heading, avg_pitch, avg_roll, peak_hold;
    bit primed;

    request_t     pending_reqs[$];
    tilt_result_t expected_results[$];
    request_t     cur_req;
    bit           took;        // current request accepted at the last rising edge
    bit           hold_sender; // sender paused by the stimulus thread
    bit           quiet;       // no idling on either side
    int           errors, n_accepted, n_results, n_clears, n_unit_changes;
    longint       cycles;

    // ------------------------------------------------------------------
    // model arithmetic
    // ------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic int sqrt_nearest(longint unsigned s);
        longint unsigned r;
        r = int_sqrt(s);
        if (s - r * r > r)
            r++;
        return int'(r);
    endfunction

    // vectoring cordic, result in 1/64 degree with saturation
    function automatic int cordic_angle(longint y, longint x, int lim);
        longint z, t, nx, ny, v;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = QUARTER_TURN;
            end
            else
            begin
                x = -y; y = t; z = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_Q16[i];
            end
            else
            begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_Q16[i];
            end
            x = nx; y = ny;
        end
        v = (z + 512) >>> 10;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return int'(v);
    endfunction

    // rounded 0.4 step
    function automatic int smooth_step(int d);
        int a, s;
        a = d < 0 ? -d : d;
        s = (4 * a + 5) / 10;
        return d < 0 ? -s : s;
    endfunction

    function automatic longint to_g(logic [15:0] raw);
        longint v;
        v = longint'($signed(raw));
        if (unit_is_g)
            return v;
        return (v * MPS2_SCALE + 32768) >>> 16;
    endfunction

    // advance the tracker model by one request and return its result
    function automatic tilt_result_t track_request(request_t rq);
        tilt_result_t r;
        int old[9];
        longint gx, gy, gz;
        longint unsigned sxx, syy, szz;
        int planar, total, heading, pitch, roll, d;
        old = '{avg_x, avg_y, avg_z, avg_total, avg_planar, avg_heading, avg_pitch,
                avg_roll, peak_hold};
        if (rq.kind == OP_CLEAR)
            peak_hold = 0;
        else
        begin
            gx = to_g(rq.ax);
            gy = to_g(rq.ay);
            gz = to_g(rq.az);
            sxx = gx * gx;
            syy = gy * gy;
            szz = gz * gz;
            planar = sqrt_nearest(sxx + syy);
            total = sqrt_nearest(sxx + syy + szz);
            heading = cordic_angle(gy * 256, gx * 256, HEADING_MAX);
            pitch = cordic_angle(gx * 256, longint'(int_sqrt((syy + szz) << 16)), TILT_MAX);
            roll = cordic_angle(gy * 256, longint'(int_sqrt((sxx + szz) << 16)), TILT_MAX);
            if (!primed)
            begin
                avg_x = int'(gx); avg_y = int'(gy); avg_z = int'(gz);
                avg_total = total; avg_planar = planar; avg_heading = heading;
                avg_pitch = pitch; avg_roll = roll;
                primed = 1'b1;
            end
            else
            begin
                avg_x += smooth_step(int'(gx) - avg_x);
                avg_y += smooth_step(int'(gy) - avg_y);
                avg_z += smooth_step(int'(gz) - avg_z);
                avg_total += smooth_step(total - avg_total);
                avg_planar += smooth_step(planar - avg_planar);
                avg_pitch += smooth_step(pitch - avg_pitch);
                avg_roll += smooth_step(roll - avg_roll);
                // heading takes the short way round, then is folded back
                d = heading - avg_heading;
                if (d > HEADING_MAX) d -= TURN_64THS;
                else if (d < -HEADING_MAX) d += TURN_64THS;
                avg_heading += smooth_step(d);
                if (avg_heading > HEADING_MAX) avg_heading -= TURN_64THS;
                else if (avg_heading < -HEADING_MAX) avg_heading += TURN_64THS;
            end
            if (total > peak_hold)
                peak_hold = total;
        end
        r.chg = old[0] != avg_x || old[1] != avg_y || old[2] != avg_z ||
                old[3] != avg_total || old[4] != avg_planar || old[5] != avg_heading ||
                old[6] != avg_pitch || old[7] != avg_roll || old[8] != peak_hold;
        r.fx = avg_x[15:0];
        r.fy = avg_y[15:0];
        r.fz = avg_z[15:0];
        r.ftotal = avg_total[15:0];
        r.fplanar = avg_planar[15:0];
        r.fheading = avg_heading[14:0];
        r.fpitch = avg_pitch[13:0];
        r.froll = avg_roll[13:0];
        r.peak = peak_hold[15:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: accept requests and check results at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        tilt_result_t e;
        cycles++;
        if (rst_n && in_valid && !in_stall)
        begin
            expected_results.push_back(track_request(cur_req));
            took = 1'b1;
            n_accepted++;
            if (cur_req.kind == OP_CLEAR)
                n_clears++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request outstanding", $time);
            end
            else
            begin
                e = expected_results.pop_front();
                check_field("filt_x", e.fx, filt_x);
                check_field("filt_y", e.fy, filt_y);
                check_field("filt_z", e.fz, filt_z);
                check_field("filt_total", e.ftotal, filt_total);
                check_field("filt_planar", e.fplanar, filt_planar);
                check_field("filt_heading", 16'(e.fheading), 16'(filt_heading[14:0]));
                check_field("filt_pitch", 16'(e.fpitch), 16'(filt_pitch[13:0]));
                check_field("filt_roll", 16'(e.froll), 16'(filt_roll[13:0]));
                check_field("peak_total", e.peak, peak_total);
                check_field("changed", 16'(e.chg), 16'(changed));
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // driver: new request and random stalls at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= !quiet && ($urandom_range(99) < 7);
            if (!in_valid || took)
            begin
                took = 1'b0;
                if (pending_reqs.size() > 0 && !hold_sender &&
                    (quiet || $urandom_range(99) >= 7))
                begin
                    cur_req = pending_reqs.pop_front();
                    op <= cur_req.kind;
                    sample_x <= cur_req.ax;
                    sample_y <= cur_req.ay;
                    sample_z <= cur_req.az;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic add_req(op_e k, int x, int y, int z);
        request_t rq;
        rq.kind = k;
        rq.ax = x[15:0];
        rq.ay = y[15:0];
        rq.az = z[15:0];
        pending_reqs.push_back(rq);
    endtask

    // wait until every queued request has been answered
    task automatic drain();
        do
            @(posedge clk);
        while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // apb write: setup then access, model updated after the access
    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_INPUT_IN_G && data[0] != unit_is_g)
        begin
            unit_is_g = data[0];
            peak_hold = 0;
            primed = 1'b0;
            n_unit_changes++;
        end
        // register reads back the unit setting
        if (prdata !== {31'd0, unit_is_g} || pready !== 1'b1)
        begin
            errors++;
            $display("%0t: prdata mismatch, expected %0h, got %0h", $time,
                     {31'd0, unit_is_g}, prdata);
        end
    endtask

    // one axis value: mostly near 1 g in the current unit, some full range
    function automatic int rand_axis(bit in_g);
        int one_g;
        one_g = in_g ? 256 : 2511;
        if ($urandom_range(9) < 2)
            return int'($signed(16'($urandom)));
        return $urandom_range(4 * one_g) - 2 * one_g;
    endfunction

    task automatic random_phase(int n);
        int x, y;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 8)
                add_req(OP_CLEAR, $urandom, $urandom, $urandom);
            else if ($urandom_range(9) == 0)
            begin
                // near the negative x axis so the heading wraps
                x = -int'($urandom_range(3000, 200));
                y = $urandom_range(40) - 20;
                add_req(OP_SAMPLE, x, y, rand_axis(unit_is_g));
            end
            else
                add_req(OP_SAMPLE, rand_axis(unit_is_g), rand_axis(unit_is_g),
                        rand_axis(unit_is_g));
        end
        drain();
    endtask

    task automatic directed_set();
        add_req(OP_SAMPLE, 0, 0, 0);                  // zero vector loads the filter
        add_req(OP_SAMPLE, -32768, 0, 0);             // negative x axis, heading +180
        add_req(OP_SAMPLE, -32768, 5, 0);             // wrap across +-180
        add_req(OP_SAMPLE, -32768, -5, 0);
        add_req(OP_SAMPLE, 32767, 32767, 32767);
        add_req(OP_SAMPLE, -32768, -32768, -32768);
        add_req(OP_SAMPLE, 0, 32767, 0);
        add_req(OP_SAMPLE, 0, 0, -32768);
        add_req(OP_CLEAR, 16'hffff, 16'hffff, 16'hffff);
        add_req(OP_CLEAR, 0, 0, 0);                   // clear with peak already zero
        add_req(OP_SAMPLE, 1, -1, 1);                 // small +-1 sample
        add_req(OP_SAMPLE, 0, 0, 0);
    endtask

    initial
    begin
        quiet = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // metres per second squared after reset
        directed_set();
        drain();
        reg_write(ADDR_INPUT_IN_G, 32'd1);
        directed_set();
        drain();
        reg_write(ADDR_INPUT_IN_G, 32'd1);            // same value, no effect
        reg_write(ADDR_UNUSED, 32'd0);                // unmapped, ignored

        // sender held until every result is back
        random_phase(150);
        hold_sender = 1'b1;
        random_phase(0);
        hold_sender = 1'b0;

        quiet = 1'b1;                                 // stretch with no idling
        random_phase(250);
        quiet = 1'b0;
        reg_write(ADDR_INPUT_IN_G, 32'd0);
        random_phase(400);
        reg_write(ADDR_INPUT_IN_G, 32'hffff_ffff);
        random_phase(400);

        $display("%0d requests (%0d peak clears), %0d unit changes, %0d results checked",
                 n_accepted, n_clears, n_unit_changes, n_results);
        $display("both units, directed extremes and wraps, random samples with stalls");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
